[rtl/core/dcpsl_pkg.sv]
// dcpsl_pkg: shared types and constants of the dual channel pid speed loop
// used by dcpsl_chan and dual_channel_pid_speed_loop, no dependencies

package dcpsl_pkg;

    localparam int COUNT_BITS_DEF     = 32;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int COUNT_IN_W = 32;
    localparam int TARGET_W   = 16;
    localparam int SPEED_W    = 16;
    localparam int DRIVE_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 17;
    localparam int LAST_ERR_W = 18;
    localparam int INTEG_W    = 14;
    localparam int ACC_W      = 36;

    localparam int INTEG_LIMIT = 5000;
    localparam int DRIVE_LIMIT = 100;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 48;
    localparam int CFG_ADDR_W = 3;

    localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd512;
    localparam logic signed [GAIN_W-1:0] KI_RESET = 16'sd0;
    localparam logic signed [GAIN_W-1:0] KD_RESET = 16'sd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEFT_KP  = 3'd0,
        REG_LEFT_KI  = 3'd1,
        REG_LEFT_KD  = 3'd2,
        REG_RIGHT_KP = 3'd3,
        REG_RIGHT_KI = 3'd4,
        REG_RIGHT_KD = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } t_gains;

endpackage

[rtl/core/dcpsl_chan.sv]
// dcpsl_chan: one channel of the speed loop, speed measurement, pid and state
// depends on dcpsl_pkg

module dcpsl_chan #(
    parameter int COUNT_BITS     = dcpsl_pkg::COUNT_BITS_DEF,
    parameter int GAIN_FRAC_BITS = dcpsl_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_step,
    input  logic                                     i_enable,
    input  logic signed [dcpsl_pkg::COUNT_IN_W-1:0]  i_count,
    input  logic signed [dcpsl_pkg::TARGET_W-1:0]    i_target,
    input  dcpsl_pkg::t_gains                        i_gains,
    output logic signed [dcpsl_pkg::DRIVE_W-1:0]     o_drive,
    output logic signed [dcpsl_pkg::SPEED_W-1:0]     o_speed
);
    import dcpsl_pkg::*;

    localparam logic signed [COUNT_BITS-1:0] SAT_HI = COUNT_BITS'(32767);
    localparam logic signed [COUNT_BITS-1:0] SAT_LO = COUNT_BITS'(-32768);
    localparam logic signed [LAST_ERR_W-1:0] INTEG_HI = LAST_ERR_W'(INTEG_LIMIT);
    localparam logic signed [LAST_ERR_W-1:0] INTEG_LO = LAST_ERR_W'(-INTEG_LIMIT);
    localparam logic signed [ACC_W-1:0] ROUND_ADJ = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [ACC_W-1:0] DRIVE_HI = ACC_W'(DRIVE_LIMIT);
    localparam logic signed [ACC_W-1:0] DRIVE_LO = ACC_W'(-DRIVE_LIMIT);

    logic signed [COUNT_BITS-1:0] r_prev_count, n_prev_count;
    logic signed [INTEG_W-1:0]    r_integ, n_integ;
    logic signed [LAST_ERR_W-1:0] r_last_err, n_last_err;
    logic signed [SPEED_W-1:0]    r_meas, n_meas;

    logic signed [63:0]           w_cur_ext;
    logic signed [COUNT_BITS-1:0] w_cur;
    logic signed [COUNT_BITS-1:0] w_diff;
    logic signed [SPEED_W-1:0]    w_speed;
    logic signed [ERR_W-1:0]      w_err;
    logic signed [LAST_ERR_W-1:0] w_deriv;
    logic signed [LAST_ERR_W-1:0] w_integ_sum;
    logic signed [INTEG_W-1:0]    w_integ;
    logic signed [32:0]           w_p_kp;
    logic signed [29:0]           w_p_ki;
    logic signed [33:0]           w_p_kd;
    logic signed [ACC_W-1:0]      w_acc;
    logic signed [ACC_W-1:0]      w_acc_adj;
    logic signed [ACC_W-1:0]      w_quot;
    logic signed [DRIVE_W-1:0]    w_drive;

    // wrapped count difference, saturated to 16 bits
    assign w_cur_ext = 64'(i_count);
    assign w_cur     = w_cur_ext[COUNT_BITS-1:0];
    assign w_diff    = w_cur - r_prev_count;

    always_comb begin
        priority if (w_diff > SAT_HI) begin
            w_speed = 16'sh7FFF;
        end else if (w_diff < SAT_LO) begin
            w_speed = 16'sh8000;
        end else begin
            w_speed = w_diff[SPEED_W-1:0];
        end
    end

    assign w_err       = ERR_W'(i_target) - ERR_W'(w_speed);
    assign w_deriv     = LAST_ERR_W'(w_err) - r_last_err;
    assign w_integ_sum = LAST_ERR_W'(r_integ) + LAST_ERR_W'(w_err);

    always_comb begin
        priority if (w_integ_sum > INTEG_HI) begin
            w_integ = INTEG_W'(INTEG_LIMIT);
        end else if (w_integ_sum < INTEG_LO) begin
            w_integ = INTEG_W'(-INTEG_LIMIT);
        end else begin
            w_integ = w_integ_sum[INTEG_W-1:0];
        end
    end

    assign w_p_kp = i_gains.kp * w_err;
    assign w_p_ki = i_gains.ki * w_integ;
    assign w_p_kd = i_gains.kd * w_deriv;
    assign w_acc  = ACC_W'(w_p_kp) + ACC_W'(w_p_ki) + ACC_W'(w_p_kd);

    // shift with truncation toward zero
    assign w_acc_adj = w_acc + (w_acc[ACC_W-1] ? ROUND_ADJ : '0);
    assign w_quot    = w_acc_adj >>> GAIN_FRAC_BITS;

    always_comb begin
        priority if (w_quot > DRIVE_HI) begin
            w_drive = DRIVE_W'(DRIVE_LIMIT);
        end else if (w_quot < DRIVE_LO) begin
            w_drive = DRIVE_W'(-DRIVE_LIMIT);
        end else begin
            w_drive = w_quot[DRIVE_W-1:0];
        end
    end

    assign o_drive = i_enable ? w_drive : '0;
    assign o_speed = i_enable ? w_speed : r_meas;

    always_comb begin
        n_prev_count = r_prev_count;
        n_integ      = r_integ;
        n_last_err   = r_last_err;
        n_meas       = r_meas;
        if (i_step) begin
            n_prev_count = w_cur;
            if (i_enable) begin
                n_integ    = w_integ;
                n_last_err = LAST_ERR_W'(w_err);
                n_meas     = w_speed;
            end else begin
                n_integ = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_count <= '0;
            r_integ      <= '0;
            r_last_err   <= '0;
            r_meas       <= '0;
        end else begin
            r_prev_count <= n_prev_count;
            r_integ      <= n_integ;
            r_last_err   <= n_last_err;
            r_meas       <= n_meas;
        end
    end

endmodule

[rtl/core/dual_channel_pid_speed_loop.sv]
// dual_channel_pid_speed_loop: top level, stream ports, gain registers, output stage
// depends on dcpsl_pkg and dcpsl_chan
//
// usage
// - slave stream: one transfer per control period, tdata carries both encoder
//   counts and both target speeds, tuser carries the enable flag
// - master stream: one transfer per input transfer, both drives and both speeds
// - gain registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata; the user
//   must do so only while no transfer is in flight, the block does not enforce this;
//   indexes 6 and 7 are ignored
// - throughput: one transfer per cycle while the master side keeps up; the pid
//   math of both channels sits between the input register and the output register,
//   and the channel state is updated when an item moves into the output register
// - a stalled master side holds the output register; the input register still
//   takes one more transfer, then o_s_tready drops until the output moves
// - reset (synchronous, active low) empties both stages, clears count baselines,
//   integrals, last errors and speeds, and loads kp = 2.0, ki = kd = 0

module dual_channel_pid_speed_loop #(
    parameter int COUNT_BITS     = dcpsl_pkg::COUNT_BITS_DEF,
    parameter int GAIN_FRAC_BITS = dcpsl_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // count_left, count_right, target_left, target_right
    input  logic [dcpsl_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // enable
    input  logic                                  i_s_tuser,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // drive_left, drive_right, speed_left, speed_right
    output logic [dcpsl_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic                                  i_cfg_we,
    input  logic [dcpsl_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [dcpsl_pkg::GAIN_W-1:0]          i_cfg_wdata
);
    import dcpsl_pkg::*;

    logic                           r_in_valid;
    logic signed [COUNT_IN_W-1:0]   r_count_left, r_count_right;
    logic signed [TARGET_W-1:0]     r_target_left, r_target_right;
    logic                           r_enable;

    logic                           r_out_valid;
    logic [M_TDATA_W-1:0]           r_out_data;

    t_gains                         r_gains_left, r_gains_right;
    t_gains                         n_gains_left, n_gains_right;

    logic                           w_advance;
    logic                           w_in_load;
    logic signed [DRIVE_W-1:0]      w_drive_left, w_drive_right;
    logic signed [SPEED_W-1:0]      w_speed_left, w_speed_right;

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_in_load  = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_gains_left  = r_gains_left;
        n_gains_right = r_gains_right;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_LEFT_KP:  n_gains_left.kp  = i_cfg_wdata;
                REG_LEFT_KI:  n_gains_left.ki  = i_cfg_wdata;
                REG_LEFT_KD:  n_gains_left.kd  = i_cfg_wdata;
                REG_RIGHT_KP: n_gains_right.kp = i_cfg_wdata;
                REG_RIGHT_KI: n_gains_right.ki = i_cfg_wdata;
                REG_RIGHT_KD: n_gains_right.kd = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains_left  <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET};
            r_gains_right <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET};
        end else begin
            r_gains_left  <= n_gains_left;
            r_gains_right <= n_gains_right;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_count_left   <= i_s_tdata[31:0];
            r_count_right  <= i_s_tdata[63:32];
            r_target_left  <= i_s_tdata[79:64];
            r_target_right <= i_s_tdata[95:80];
            r_enable       <= i_s_tuser;
        end
    end

    dcpsl_chan #(
        .COUNT_BITS     (COUNT_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_chan_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_enable (r_enable),
        .i_count  (r_count_left),
        .i_target (r_target_left),
        .i_gains  (r_gains_left),
        .o_drive  (w_drive_left),
        .o_speed  (w_speed_left)
    );

    dcpsl_chan #(
        .COUNT_BITS     (COUNT_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_chan_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_enable (r_enable),
        .i_count  (r_count_right),
        .i_target (r_target_right),
        .i_gains  (r_gains_right),
        .o_drive  (w_drive_right),
        .o_speed  (w_speed_right)
    );

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {w_speed_right, w_speed_left, w_drive_right, w_drive_left};
        end
    end

endmodule

[test/dcpsl_loop_checker.sv]
`timescale 1ns / 100ps
// dcpsl_loop_checker: watches the slave, master and gain write ports of the speed loop,
// predicts every drive and speed transfer and compares it with what the block sends
// depends on dcpsl_pkg

module dcpsl_loop_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [dcpsl_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [dcpsl_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             i_cfg_we,
    input  logic [dcpsl_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dcpsl_pkg::GAIN_W-1:0]     i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import dcpsl_pkg::*;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive_left;
        logic signed [DRIVE_W-1:0] drive_right;
        logic signed [SPEED_W-1:0] speed_left;
        logic signed [SPEED_W-1:0] speed_right;
    } t_loop_result;

    typedef struct {
        int                        kp;
        int                        ki;
        int                        kd;
        logic [COUNT_IN_W-1:0]     base;
        int                        integ;
        int                        last_err;
        logic signed [SPEED_W-1:0] meas;
    } t_chan_state;

    t_chan_state  chans [2];
    t_loop_result predicted_drives [$];
    int           fail_total;

    function automatic logic signed [SPEED_W-1:0] measure_speed(
        input logic [COUNT_IN_W-1:0] cur,
        input logic [COUNT_IN_W-1:0] prev
    );
        logic signed [COUNT_IN_W-1:0] d;
        d = cur - prev;
        if (d > 32767) return 16'sh7FFF;
        if (d < -32768) return 16'sh8000;
        return d[SPEED_W-1:0];
    endfunction

    function automatic logic signed [DRIVE_W-1:0] pid_drive(
        input int                         c,
        input logic signed [TARGET_W-1:0] target
    );
        int     err;
        int     deriv;
        int     sum;
        longint acc;
        longint q;
        err = int'(target) - int'(chans[c].meas);
        deriv = err - chans[c].last_err;
        chans[c].last_err = err;
        sum = chans[c].integ + err;
        if (sum > INTEG_LIMIT) sum = INTEG_LIMIT;
        if (sum < -INTEG_LIMIT) sum = -INTEG_LIMIT;
        chans[c].integ = sum;
        acc = longint'(chans[c].kp) * err + longint'(chans[c].ki) * sum
            + longint'(chans[c].kd) * deriv;
        q = acc / longint'(2 ** GAIN_FRAC_BITS_DEF);
        if (q > DRIVE_LIMIT) q = DRIVE_LIMIT;
        if (q < -DRIVE_LIMIT) q = -DRIVE_LIMIT;
        return q[DRIVE_W-1:0];
    endfunction

    function automatic t_loop_result predict_period(
        input logic [S_TDATA_W-1:0] data,
        input logic                 enable
    );
        logic [COUNT_IN_W-1:0]      cnt [2];
        logic signed [TARGET_W-1:0] tgt [2];
        logic signed [DRIVE_W-1:0]  drv [2];
        t_loop_result               r;
        cnt[0] = data[31:0];
        cnt[1] = data[63:32];
        tgt[0] = data[79:64];
        tgt[1] = data[95:80];
        for (int c = 0; c < 2; c++) begin
            drv[c] = '0;
            if (enable) begin
                chans[c].meas = measure_speed(cnt[c], chans[c].base);
                chans[c].base = cnt[c];
                drv[c] = pid_drive(c, tgt[c]);
            end else begin
                chans[c].base = cnt[c];
                chans[c].integ = 0;
            end
        end
        r.drive_left = drv[0];
        r.drive_right = drv[1];
        r.speed_left = chans[0].meas;
        r.speed_right = chans[1].meas;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_loop_result got;
        t_loop_result want;
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                chans[c].kp = KP_RESET;
                chans[c].ki = KI_RESET;
                chans[c].kd = KD_RESET;
                chans[c].base = '0;
                chans[c].integ = 0;
                chans[c].last_err = 0;
                chans[c].meas = '0;
            end
            predicted_drives.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_LEFT_KP:  chans[0].kp = int'($signed(i_cfg_wdata));
                    REG_LEFT_KI:  chans[0].ki = int'($signed(i_cfg_wdata));
                    REG_LEFT_KD:  chans[0].kd = int'($signed(i_cfg_wdata));
                    REG_RIGHT_KP: chans[1].kp = int'($signed(i_cfg_wdata));
                    REG_RIGHT_KI: chans[1].ki = int'($signed(i_cfg_wdata));
                    REG_RIGHT_KD: chans[1].kd = int'($signed(i_cfg_wdata));
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.drive_left = i_m_tdata[7:0];
                got.drive_right = i_m_tdata[15:8];
                got.speed_left = i_m_tdata[31:16];
                got.speed_right = i_m_tdata[47:32];
                if (predicted_drives.size() == 0) begin
                    $error("result transfer with no input outstanding");
                    fail_total++;
                end else begin
                    want = predicted_drives.pop_front();
                    compare_field("drive_left", want.drive_left, got.drive_left);
                    compare_field("drive_right", want.drive_right, got.drive_right);
                    compare_field("speed_left", want.speed_left, got.speed_left);
                    compare_field("speed_right", want.speed_right, got.speed_right);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predicted_drives.push_back(predict_period(i_s_tdata, i_s_tuser));
        end
        o_pending <= predicted_drives.size();
        o_fail_count <= fail_total;
    end

endmodule

[test/dual_channel_pid_speed_loop_tb.sv]
`timescale 1ns / 100ps
// dual_channel_pid_speed_loop_tb: drives control periods and gain writes into the speed loop
// under random stalls on both streams and gives the verdict
// depends on dcpsl_pkg, dual_channel_pid_speed_loop and dcpsl_loop_checker

module dual_channel_pid_speed_loop_tb;
    import dcpsl_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 322;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [GAIN_W-1:0]     cfg_wdata = '0;
    int                    fail_count;
    int                    pending;

    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    int                    quiet_cycles = 0;
    logic [31:0]           cnt_left = '0;
    logic [31:0]           cnt_right = '0;
    int                    goal_left = 0;
    int                    goal_right = 0;

    dual_channel_pid_speed_loop dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    dcpsl_loop_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("dual_channel_pid_speed_loop test failed");
                $finish;
            end
        end
    end

    task automatic send_period(
        input logic [31:0] cl,
        input logic [31:0] cr,
        input logic [15:0] tl,
        input logic [15:0] tr,
        input logic        en
    );
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {tr, tl, cr, cl};
        s_tuser <= en;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        cnt_left = cl;
        cnt_right = cr;
    endtask

    task automatic send_random_period();
        logic [31:0] cl;
        logic [31:0] cr;
        logic [15:0] tl;
        logic [15:0] tr;
        logic        en;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            en = (pick >= 5);
            cl = $urandom;
            cr = $urandom;
            tl = $urandom;
            tr = $urandom;
        end else begin
            if ($urandom_range(19) == 0) goal_left = int'($urandom_range(800)) - 400;
            if ($urandom_range(19) == 0) goal_right = int'($urandom_range(800)) - 400;
            // walk across the signed wrap of the counters now and then
            if ($urandom_range(199) == 0) cnt_left = 32'h7FFF_FF00;
            if ($urandom_range(199) == 0) cnt_right = 32'h8000_0100;
            cl = cnt_left + goal_left + int'($urandom_range(60)) - 30;
            cr = cnt_right + goal_right + int'($urandom_range(60)) - 30;
            tl = goal_left[15:0];
            tr = goal_right[15:0];
            en = ($urandom_range(24) != 0);
        end
        send_period(cl, cr, tl, tr, en);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_gain(input logic [CFG_ADDR_W-1:0] addr, input int value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value[GAIN_W-1:0];
        @(posedge clk);
    endtask

    task automatic load_gains(input int g [6]);
        write_gain(REG_LEFT_KP, g[0]);
        write_gain(REG_LEFT_KI, g[1]);
        write_gain(REG_LEFT_KD, g[2]);
        write_gain(REG_RIGHT_KP, g[3]);
        write_gain(REG_RIGHT_KI, g[4]);
        write_gain(REG_RIGHT_KD, g[5]);
        write_gain(REG_SPARE_LO, $urandom);
        write_gain(REG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_gain_set(input int set, output int g [6]);
        case (set)
            0: g = '{300, 12, 40, 420, 8, -30};
            1: g = '{32767, 32767, 32767, -32768, -32768, -32768};
            2: g = '{0, 0, 0, 1, 1, 1};
            3: foreach (g[i]) g[i] = $urandom;
            4: foreach (g[i]) g[i] = int'($urandom_range(2048)) - 1024;
            default: g = '{512, 0, 0, -32768, 32767, 0};
        endcase
    endtask

    initial begin
        int gains [6];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 32;
        rx_idle_pct = 81;

        gains = '{512, 64, 128, -256, -32, -64};
        load_gains(gains);
        send_period(0, 0, 0, 0, 1'b0);
        send_period(10, -10, 10, -10, 1'b1);
        send_period(20, -20, 32767, -32768, 1'b1);
        send_period(100020, -100020, 0, 0, 1'b1);
        send_period(32'h7FFF_FFF0, 32'h8000_0010, -32768, 32767, 1'b1);
        send_period(32'h8000_0010, 32'h7FFF_FFF0, 5, -5, 1'b1);
        send_period(32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 1'b1);
        send_period(32'h0000_7FFF, 32'hFFFF_8000, 0, 0, 1'b1);
        send_period(32'h0000_FFFF, 32'hFFFF_0000, 0, 0, 1'b1);
        send_period(32'h0001_7FFF, 32'hFFFE_7FFF, 0, 0, 1'b1);
        send_period(32'h0001_7FFF, 32'hFFFE_7FFF, 30000, -30000, 1'b1);
        send_period(32'h0001_7FFF, 32'hFFFE_7FFF, 30000, -30000, 1'b1);
        send_period(32'h0001_7FFF, 32'hFFFE_7FFF, 30000, -30000, 1'b1);
        send_period(32'h0001_7FFF, 32'hFFFE_7FFF, -30000, 30000, 1'b1);
        send_period(32'h0001_7FFF, 32'hFFFE_7FFF, -30000, 30000, 1'b1);
        send_period(32'h0001_7FFF, 32'hFFFE_7FFF, -30000, 30000, 1'b1);
        send_period(500, 500, 0, 0, 1'b0);
        send_period(900, 100, 77, -77, 1'b0);
        send_period(910, 90, 10, -10, 1'b1);
        send_period(925, 70, 12, -25, 1'b1);

        for (int set = 0; set < 6; set++) begin
            if (set == 2) begin
                tx_idle_pct = 81;
                rx_idle_pct = 32;
            end
            if (set == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            drain_results();
            pick_gain_set(set, gains);
            load_gains(gains);
            repeat (ITEMS_PER_PHASE) send_random_period();
        end
        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("dual_channel_pid_speed_loop test passed");
        else
            $display("dual_channel_pid_speed_loop test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/dcpsl_pkg.sv
rtl/core/dcpsl_chan.sv
rtl/core/dual_channel_pid_speed_loop.sv
test/dcpsl_loop_checker.sv
test/dual_channel_pid_speed_loop_tb.sv
